>>> hw/rtl/elastic_collision_impulse_2d_assert.svh
// assertion macros shared by the collision impulse rtl
// expects clk and rst_n in the scope of use
`ifndef ELASTIC_COLLISION_IMPULSE_2D_ASSERT_SVH
`define ELASTIC_COLLISION_IMPULSE_2D_ASSERT_SVH

`ifndef SYNTHESIS
`define ECI_ASSERT_IMP(lbl, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
    else $error("assertion failed");
`define ECI_ASSERT_NXT(lbl, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) \
    else $error("assertion failed");
`else
`define ECI_ASSERT_IMP(lbl, pre, con)
`define ECI_ASSERT_NXT(lbl, pre, con)
`endif

`endif

>>> hw/rtl/eci_pkg.sv
// widths, outcome codes and pipeline payload types of the collision impulse unit
// no dependencies
package eci_pkg;

  localparam int POS_W   = 21;
  localparam int VEL_W   = 24;
  localparam int MASS_W  = 20;
  localparam int RST_W   = 9;
  localparam int E_W     = 10;
  localparam int D_W     = 22;
  localparam int AD_W    = 22;
  localparam int R_W     = 25;
  localparam int PROD_W  = 47;
  localparam int DOT_W   = 48;
  localparam int ADOT_W  = 47;
  localparam int SQ_W    = 43;
  localparam int DD_W    = 44;
  localparam int SUM_W   = 21;
  localparam int A_W     = 57;
  localparam int ALO_W   = 29;
  localparam int AHI_W   = A_W - ALO_W;
  localparam int CM_W    = AD_W + MASS_W;
  localparam int PLO_W   = ALO_W + CM_W;
  localparam int PHI_W   = AHI_W + CM_W;
  localparam int DEN0_W  = DD_W + SUM_W;
  localparam int DW      = DEN0_W + 9;
  localparam int NW      = 101;
  localparam int QW      = 27;
  localparam int NQ      = 4;
  localparam int EXT_W   = VEL_W + 5;
  localparam int OC_W    = 2;
  localparam int IN_W    = 224;
  localparam int OUT_W   = 4 * VEL_W;

  localparam logic [RST_W-1:0] RST_ONE = 9'd256;

  localparam logic [OC_W-1:0] OC_IMPULSE    = 2'd0;
  localparam logic [OC_W-1:0] OC_COINCIDENT = 2'd1;
  localparam logic [OC_W-1:0] OC_SEPARATING = 2'd2;

  typedef struct packed {
    logic signed [VEL_W-1:0] v1x;
    logic signed [VEL_W-1:0] v1y;
    logic signed [VEL_W-1:0] v2x;
    logic signed [VEL_W-1:0] v2y;
    logic                    neg_x;
    logic                    neg_y;
    logic [OC_W-1:0]         oc;
  } side_t;

  typedef struct packed {
    logic [NQ-1:0][NW-1:0] rem;
    logic [DW-1:0]         den;
    logic [NQ-1:0][QW-1:0] q;
    side_t                 side;
  } div_t;

endpackage

>>> hw/rtl/eci_divider.sv
// pipelined restoring divider, one quotient bit per stage, four quotients sharing a divisor
// depends on eci_pkg and elastic_collision_impulse_2d_assert.svh
`include "elastic_collision_impulse_2d_assert.svh"

module eci_divider
  import eci_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  div_t                  in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [NQ-1:0][QW-1:0] out_q,
  output side_t                 out_side
);

  div_t st_r [QW];
  logic v_r  [QW];
  logic rdy  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    div_t cur;
    div_t nxt;
    logic cur_v;

    if (k == 0) begin : g_first
      assign cur   = in_word;
      assign cur_v = in_valid;
    end else begin : g_next
      assign cur   = st_r[k-1];
      assign cur_v = v_r[k-1];
    end

    if (k == QW - 1) begin : g_last
      assign rdy[k] = !v_r[k] || out_ready;
    end else begin : g_mid
      assign rdy[k] = !v_r[k] || rdy[k+1];
    end

    always_comb begin
      nxt = cur;
      for (int j = 0; j < NQ; j++) begin
        if (cur.rem[j] >= (NW'(cur.den) << B)) begin
          nxt.rem[j]  = cur.rem[j] - (NW'(cur.den) << B);
          nxt.q[j][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        st_r[k] <= nxt;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[QW-1];
  assign out_q     = st_r[QW-1].q;
  assign out_side  = st_r[QW-1].side;

  `ECI_ASSERT_IMP(a_rem_below_den, v_r[QW-1] && st_r[QW-1].side.oc == OC_IMPULSE, st_r[QW-1].rem[0] < NW'(st_r[QW-1].den) && st_r[QW-1].rem[1] < NW'(st_r[QW-1].den) && st_r[QW-1].rem[2] < NW'(st_r[QW-1].den) && st_r[QW-1].rem[3] < NW'(st_r[QW-1].den))
  `ECI_ASSERT_NXT(a_last_holds, v_r[QW-1] && !out_ready, v_r[QW-1])
  `ECI_ASSERT_IMP(a_ready_when_empty, !v_r[0], in_ready)

endmodule

>>> hw/rtl/elastic_collision_impulse_2d.sv
// Two-body 2D impulse collision response. One body pair is taken per clock cycle with no
// gaps while the output is not stalled. The pipeline consists of six front stages
// (differences, products, dot product, scale, partial products, numerator sum), the
// 27-stage restoring divider that makes one quotient bit per stage, and the saturating
// output register. A stall on the output reaches the input in the same
// cycle through the ready chain, and empty stages keep filling, so bubbles are squeezed
// out. Restitution is read live and should be written while idle.
// depends on eci_pkg, eci_divider and elastic_collision_impulse_2d_assert.svh
`include "elastic_collision_impulse_2d_assert.svh"

module elastic_collision_impulse_2d
  import eci_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [RST_W-1:0] cfg_wr_data,
  input  logic             in_tvalid,
  output logic             in_tready,
  // first_pos_x, first_pos_y, second_pos_x, second_pos_y, first_vel_x, first_vel_y,
  // second_vel_x, second_vel_y, first_mass, second_mass, zero pad
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y
  output logic [OUT_W-1:0] out_tdata,
  // outcome
  output logic [OC_W-1:0]  out_tuser
);

  logic [RST_W-1:0] restitution_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restitution_r <= RST_ONE;
    end else if (cfg_wr_en) begin
      restitution_r <= cfg_wr_data;
    end
  end

  // input fields
  logic signed [POS_W-1:0]  p1x, p1y, p2x, p2y;
  logic signed [VEL_W-1:0]  v1x, v1y, v2x, v2y;
  logic [MASS_W-1:0]        ma_in, mb_in, ma_fix, mb_fix;

  assign p1x   = in_tdata[20:0];
  assign p1y   = in_tdata[41:21];
  assign p2x   = in_tdata[62:42];
  assign p2y   = in_tdata[83:63];
  assign v1x   = in_tdata[107:84];
  assign v1y   = in_tdata[131:108];
  assign v2x   = in_tdata[155:132];
  assign v2y   = in_tdata[179:156];
  assign ma_in = in_tdata[199:180];
  assign mb_in = in_tdata[219:200];

  assign ma_fix = (ma_in == '0) ? MASS_W'(1) : ma_in;
  assign mb_fix = (mb_in == '0) ? MASS_W'(1) : mb_in;

  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f, rdy_g, dv_ready;

  // stage a: differences
  logic                    a_v_r;
  logic signed [D_W-1:0]   a_dx_r, a_dy_r;
  logic signed [R_W-1:0]   a_rx_r, a_ry_r;
  logic [MASS_W-1:0]       a_ma_r, a_mb_r;
  logic [SUM_W-1:0]        a_s_r;
  side_t                   a_side_r;

  assign rdy_a     = !a_v_r || rdy_b;
  assign in_tready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (rdy_a) begin
      a_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_dx_r         <= D_W'(p2x) - D_W'(p1x);
      a_dy_r         <= D_W'(p2y) - D_W'(p1y);
      a_rx_r         <= R_W'(v2x) - R_W'(v1x);
      a_ry_r         <= R_W'(v2y) - R_W'(v1y);
      a_ma_r         <= ma_fix;
      a_mb_r         <= mb_fix;
      a_s_r          <= SUM_W'(ma_fix) + SUM_W'(mb_fix);
      a_side_r.v1x   <= v1x;
      a_side_r.v1y   <= v1y;
      a_side_r.v2x   <= v2x;
      a_side_r.v2y   <= v2y;
      a_side_r.neg_x <= 1'b0;
      a_side_r.neg_y <= 1'b0;
      a_side_r.oc    <= OC_IMPULSE;
    end
  end

  // stage b: products
  logic [AD_W-1:0]           adx, ady;
  logic signed [PROD_W-1:0]  pdx, pdy;
  logic [2*AD_W-1:0]         sqx_full, sqy_full;
  logic [NQ-1:0][CM_W-1:0]   cm;
  side_t                     b_side_nxt;

  assign adx      = a_dx_r[D_W-1] ? AD_W'(-a_dx_r) : AD_W'(a_dx_r);
  assign ady      = a_dy_r[D_W-1] ? AD_W'(-a_dy_r) : AD_W'(a_dy_r);
  assign pdx      = a_rx_r * a_dx_r;
  assign pdy      = a_ry_r * a_dy_r;
  assign sqx_full = adx * adx;
  assign sqy_full = ady * ady;
  assign cm[0]    = adx * a_mb_r;
  assign cm[1]    = ady * a_mb_r;
  assign cm[2]    = adx * a_ma_r;
  assign cm[3]    = ady * a_ma_r;

  always_comb begin
    b_side_nxt       = a_side_r;
    b_side_nxt.neg_x = a_dx_r[D_W-1];
    b_side_nxt.neg_y = a_dy_r[D_W-1];
  end

  logic                      b_v_r;
  logic signed [PROD_W-1:0]  b_pdx_r, b_pdy_r;
  logic [SQ_W-1:0]           b_sqx_r, b_sqy_r;
  logic [NQ-1:0][CM_W-1:0]   b_cm_r;
  logic [SUM_W-1:0]          b_s_r;
  logic                      b_coin_r;
  side_t                     b_side_r;

  assign rdy_b = !b_v_r || rdy_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (rdy_b) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      b_pdx_r  <= pdx;
      b_pdy_r  <= pdy;
      b_sqx_r  <= sqx_full[SQ_W-1:0];
      b_sqy_r  <= sqy_full[SQ_W-1:0];
      b_cm_r   <= cm;
      b_s_r    <= a_s_r;
      b_coin_r <= (a_dx_r == '0) && (a_dy_r == '0);
      b_side_r <= b_side_nxt;
    end
  end

  // stage c: dot product, squared distance, outcome
  logic signed [DOT_W-1:0] dot;
  logic [DOT_W-1:0]        dot_neg;
  logic                    sep;
  side_t                   c_side_nxt;

  assign dot     = DOT_W'(b_pdx_r) + DOT_W'(b_pdy_r);
  assign dot_neg = DOT_W'(-dot);
  assign sep     = !dot[DOT_W-1] && (dot != '0);

  always_comb begin
    c_side_nxt = b_side_r;
    if (b_coin_r) begin
      c_side_nxt.oc = OC_COINCIDENT;
    end else if (sep) begin
      c_side_nxt.oc = OC_SEPARATING;
    end else begin
      c_side_nxt.oc = OC_IMPULSE;
    end
  end

  logic                    c_v_r;
  logic [ADOT_W-1:0]       c_adot_r;
  logic [DD_W-1:0]         c_dd_r;
  logic [NQ-1:0][CM_W-1:0] c_cm_r;
  logic [SUM_W-1:0]        c_s_r;
  side_t                   c_side_r;

  assign rdy_c = !c_v_r || rdy_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (rdy_c) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      c_adot_r <= dot[DOT_W-1] ? dot_neg[ADOT_W-1:0] : '0;
      c_dd_r   <= DD_W'(b_sqx_r) + DD_W'(b_sqy_r);
      c_cm_r   <= b_cm_r;
      c_s_r    <= b_s_r;
      c_side_r <= c_side_nxt;
    end
  end

  // stage d: restitution scale and denominator
  logic [E_W-1:0]    e_mul;
  logic [A_W-1:0]    a_full;
  logic [DEN0_W-1:0] d0_full;

  assign e_mul   = E_W'(RST_ONE) +
                   ((restitution_r > RST_ONE) ? E_W'(RST_ONE) : E_W'(restitution_r));
  assign a_full  = e_mul * c_adot_r;
  assign d0_full = c_dd_r * c_s_r;

  logic                    d_v_r;
  logic [A_W-1:0]          d_a_r;
  logic [DEN0_W-1:0]       d_d0_r;
  logic [NQ-1:0][CM_W-1:0] d_cm_r;
  side_t                   d_side_r;

  assign rdy_d = !d_v_r || rdy_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (rdy_d) begin
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d) begin
      d_a_r    <= a_full;
      d_d0_r   <= d0_full;
      d_cm_r   <= c_cm_r;
      d_side_r <= c_side_r;
    end
  end

  // stage e: partial products of the numerators
  logic [NQ-1:0][PLO_W-1:0] plo;
  logic [NQ-1:0][PHI_W-1:0] phi;

  always_comb begin
    for (int j = 0; j < NQ; j++) begin
      plo[j] = d_a_r[ALO_W-1:0] * d_cm_r[j];
      phi[j] = d_a_r[A_W-1:ALO_W] * d_cm_r[j];
    end
  end

  logic                     e_v_r;
  logic [NQ-1:0][PLO_W-1:0] e_plo_r;
  logic [NQ-1:0][PHI_W-1:0] e_phi_r;
  logic [DEN0_W-1:0]        e_d0_r;
  side_t                    e_side_r;

  assign rdy_e = !e_v_r || rdy_f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (rdy_e) begin
      e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_e) begin
      e_plo_r  <= plo;
      e_phi_r  <= phi;
      e_d0_r   <= d_d0_r;
      e_side_r <= d_side_r;
    end
  end

  // stage f: doubled numerator plus divisor for round half away from zero
  div_t f_word;

  always_comb begin
    for (int j = 0; j < NQ; j++) begin
      f_word.rem[j] = (NW'(e_phi_r[j]) << (ALO_W + 1)) + (NW'(e_plo_r[j]) << 1) +
                      (NW'(e_d0_r) << 8);
    end
    f_word.den  = {e_d0_r, 9'd0};
    f_word.q    = '0;
    f_word.side = e_side_r;
  end

  logic f_v_r;
  div_t f_word_r;

  assign rdy_f = !f_v_r || dv_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (rdy_f) begin
      f_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_f) begin
      f_word_r <= f_word;
    end
  end

  logic                  dv_valid;
  logic [NQ-1:0][QW-1:0] dv_q;
  side_t                 dv_side;

  eci_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_v_r),
    .in_ready  (dv_ready),
    .in_word   (f_word_r),
    .out_valid (dv_valid),
    .out_ready (rdy_g),
    .out_q     (dv_q),
    .out_side  (dv_side)
  );

  // stage g: apply impulse, saturate
  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [EXT_W-1:0] v);
    logic signed [VEL_W-1:0] r;
    if (v > EXT_W'(signed'(24'sh7FFFFF))) begin
      r = 24'sh7FFFFF;
    end else if (v < EXT_W'(signed'(24'sh800000))) begin
      r = 24'sh800000;
    end else begin
      r = v[VEL_W-1:0];
    end
    return r;
  endfunction

  logic signed [EXT_W-1:0] qx1, qy1, qx2, qy2;
  logic signed [VEL_W-1:0] n1x, n1y, n2x, n2y;

  assign qx1 = dv_side.neg_x ? -EXT_W'(dv_q[0]) : EXT_W'(dv_q[0]);
  assign qy1 = dv_side.neg_y ? -EXT_W'(dv_q[1]) : EXT_W'(dv_q[1]);
  assign qx2 = dv_side.neg_x ? -EXT_W'(dv_q[2]) : EXT_W'(dv_q[2]);
  assign qy2 = dv_side.neg_y ? -EXT_W'(dv_q[3]) : EXT_W'(dv_q[3]);

  assign n1x = sat_vel(EXT_W'(dv_side.v1x) - qx1);
  assign n1y = sat_vel(EXT_W'(dv_side.v1y) - qy1);
  assign n2x = sat_vel(EXT_W'(dv_side.v2x) + qx2);
  assign n2y = sat_vel(EXT_W'(dv_side.v2y) + qy2);

  logic             out_v_r;
  logic [OUT_W-1:0] out_data_r;
  logic [OC_W-1:0]  out_oc_r;

  assign rdy_g = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy_g) begin
      out_v_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_g) begin
      out_oc_r <= dv_side.oc;
      if (dv_side.oc == OC_IMPULSE) begin
        out_data_r <= {n2y, n2x, n1y, n1x};
      end else begin
        out_data_r <= {dv_side.v2y, dv_side.v2x, dv_side.v1y, dv_side.v1x};
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_oc_r;

  `ECI_ASSERT_IMP(a_stall_needs_item, !in_tready, a_v_r)
  `ECI_ASSERT_NXT(a_cfg_written, cfg_wr_en, restitution_r == $past(cfg_wr_data))
  `ECI_ASSERT_NXT(a_out_holds, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule
